### rtl/core/bafs_pkg.sv
// shared types, codes and defaults for the bit-aligned field store
package bafs_pkg;

  localparam int unsigned STORE_BYTES_DEF = 1024;
  localparam int unsigned FIELD_BITS_DEF  = 32;

  localparam int unsigned OFFSET_W = 13;
  localparam int unsigned WIDTH_W  = 6;
  localparam int unsigned VALUE_W  = 32;

  localparam logic ACT_GET = 1'b0;
  localparam logic ACT_SET = 1'b1;

  typedef struct packed {
    logic                action;
    logic [OFFSET_W-1:0] bit_offset;
    logic [WIDTH_W-1:0]  field_width;
    logic [VALUE_W-1:0]  write_value;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] field_value;
    logic               range_error;
  } out_item_t;

  typedef struct packed {
    logic issue;
    logic commit;
    logic clr_step;
  } bafs_cmd_t;

  typedef struct packed {
    logic clr_last;
  } bafs_sts_t;

endpackage

### rtl/core/bafs_bank.sv
// one byte-wide storage bank, one write port and one registered read port
module bafs_bank #(
  parameter int unsigned DEPTH  = 2,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [7:0]        wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [7:0]        rdata_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/bafs_datapath.sv
// banked byte window: read, extract, merge, write back and result register
module bafs_datapath import bafs_pkg::*; #(
  parameter int unsigned STORE_BYTES = STORE_BYTES_DEF,
  parameter int unsigned FIELD_BITS  = FIELD_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  bafs_cmd_t cmd_i,
  output bafs_sts_t sts_o,
  input  in_item_t  in_item_i,
  output out_item_t out_item_o
);

  localparam int unsigned WinBytes  = (FIELD_BITS + 14) / 8;
  localparam int unsigned LogNb     = $clog2(WinBytes);
  localparam int unsigned NumBanks  = 1 << LogNb;
  localparam int unsigned WinW      = 8 * NumBanks;
  localparam int unsigned MaxW      = (WinW > VALUE_W) ? WinW : VALUE_W;
  localparam int unsigned Rows      = (STORE_BYTES + NumBanks - 1) / NumBanks + 1;
  localparam int unsigned RowW      = $clog2(Rows);
  localparam int unsigned ByteAddrW = OFFSET_W - 3;
  localparam int unsigned RcW       = (RowW > ByteAddrW + 1) ? RowW : ByteAddrW + 1;
  localparam int unsigned StoreBits = STORE_BYTES * 8;
  localparam int unsigned OffMax    = (1 << OFFSET_W) - 1 + FIELD_BITS;
  localparam int unsigned SumMax    = (StoreBits > OffMax) ? StoreBits : OffMax;
  localparam int unsigned SumW      = $clog2(SumMax + 1);
  localparam int unsigned WW        = $clog2(FIELD_BITS + 1);
  localparam int unsigned ShW       = $clog2(WinW + 1);

  // accept side
  logic [WIDTH_W:0]     fw_ext;
  logic [WW-1:0]        w_sat;
  logic [SumW-1:0]      end_pos;
  logic                 acc_err;
  logic [ByteAddrW-1:0] s_byte;
  logic [LogNb-1:0]     s_lo;
  logic [RcW-1:0]       row_wide [NumBanks];
  logic [RowW-1:0]      rd_row   [NumBanks];

  // item registers
  logic                 act_q;
  logic                 err_q;
  logic [2:0]           o_q;
  logic [WW-1:0]        w_q;
  logic [VALUE_W-1:0]   val_q;
  logic [LogNb-1:0]     s_lo_q;
  logic [RowW-1:0]      row_q [NumBanks];

  logic [RowW-1:0]      clr_row_q;
  logic [RowW-1:0]      clr_row_d;

  // window math
  logic [7:0]           rd_data [NumBanks];
  logic [WinW-1:0]      win;
  logic [ShW-1:0]       sh;
  logic [MaxW-1:0]      fmask;
  logic [MaxW-1:0]      ext;
  logic [MaxW-1:0]      ins;
  logic [MaxW-1:0]      mwin;
  logic [MaxW-1:0]      new_win;

  logic [LogNb-1:0]     jsel       [NumBanks];
  logic [7:0]           bank_wdata [NumBanks];
  logic [RowW-1:0]      bank_waddr [NumBanks];
  logic                 bank_we    [NumBanks];
  logic                 byte_en    [NumBanks];

  out_item_t            out_q;

  always_comb begin
    fw_ext = {1'b0, in_item_i.field_width};
    if (fw_ext > (WIDTH_W + 1)'(FIELD_BITS)) begin
      w_sat = WW'(FIELD_BITS);
    end else begin
      w_sat = WW'(fw_ext);
    end
    end_pos = SumW'(in_item_i.bit_offset) + SumW'(w_sat);
    acc_err = end_pos > SumW'(StoreBits);
    s_byte  = in_item_i.bit_offset[OFFSET_W-1:3];
    s_lo    = s_byte[LogNb-1:0];
  end

  // bank b holds the window byte whose address is congruent to b
  always_comb begin
    for (int b = 0; b < NumBanks; b++) begin
      row_wide[b] = RcW'(s_byte >> LogNb) + RcW'(LogNb'(b) < s_lo);
      rd_row[b]   = row_wide[b][RowW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      act_q  <= in_item_i.action;
      err_q  <= acc_err;
      o_q    <= in_item_i.bit_offset[2:0];
      w_q    <= w_sat;
      val_q  <= in_item_i.write_value;
      s_lo_q <= s_lo;
      for (int b = 0; b < NumBanks; b++) begin
        row_q[b] <= rd_row[b];
      end
    end
  end

  assign clr_row_d = clr_row_q + RowW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_row_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_row_q <= clr_row_d;
    end
  end

  assign sts_o.clr_last = (clr_row_q == RowW'(Rows - 1));

  always_comb begin
    win = '0;
    for (int j = 0; j < NumBanks; j++) begin
      win[WinW-1-8*j -: 8] = rd_data[LogNb'(s_lo_q + LogNb'(j))];
    end
    sh      = ShW'(WinW) - ShW'(o_q) - ShW'(w_q);
    fmask   = (MaxW'(1) << w_q) - MaxW'(1);
    ext     = (MaxW'(win) >> sh) & fmask;
    ins     = (MaxW'(val_q) & fmask) << sh;
    mwin    = fmask << sh;
    new_win = (MaxW'(win) & ~mwin) | ins;
  end

  always_comb begin
    for (int b = 0; b < NumBanks; b++) begin
      jsel[b]       = LogNb'(LogNb'(b) - s_lo_q);
      byte_en[b]    = |mwin[WinW-1-8*int'(jsel[b]) -: 8];
      bank_we[b]    = cmd_i.clr_step |
                      (cmd_i.commit & (act_q == ACT_SET) & ~err_q & byte_en[b]);
      bank_waddr[b] = cmd_i.clr_step ? clr_row_q : row_q[b];
      bank_wdata[b] = cmd_i.clr_step ? 8'h00 : new_win[WinW-1-8*int'(jsel[b]) -: 8];
    end
  end

  for (genvar gb = 0; gb < NumBanks; gb++) begin : g_bank
    bafs_bank #(
      .DEPTH  (Rows),
      .ADDR_W (RowW)
    ) u_bank (
      .clk_i   (clk_i),
      .we_i    (bank_we[gb]),
      .waddr_i (bank_waddr[gb]),
      .wdata_i (bank_wdata[gb]),
      .re_i    (cmd_i.issue & ~acc_err),
      .raddr_i (rd_row[gb]),
      .rdata_o (rd_data[gb])
    );
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_q.field_value <= (act_q == ACT_GET && !err_q) ? ext[VALUE_W-1:0] : '0;
      out_q.range_error <= err_q;
    end
  end

  assign out_item_o = out_q;

endmodule

### rtl/core/bafs_ctrl.sv
// sequencer: clearing pass, item issue, commit and output valid
module bafs_ctrl import bafs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  input  bafs_sts_t sts_i,
  output bafs_cmd_t cmd_o
);

  localparam logic [1:0] StClear = 2'd0;
  localparam logic [1:0] StIdle  = 2'd1;
  localparam logic [1:0] StExec  = 2'd2;

  logic [1:0] state_q;
  logic [1:0] state_d;
  logic       out_valid_q;
  logic       out_valid_d;
  logic       out_free;

  assign out_free       = !out_valid_q || !out_stall_i;
  assign in_stall_o     = (state_q != StIdle);
  assign cmd_o.issue    = (state_q == StIdle) && in_valid_i;
  assign cmd_o.commit   = (state_q == StExec) && out_free;
  assign cmd_o.clr_step = (state_q == StClear);

  always_comb begin
    state_d = state_q;
    case (state_q)
      StClear: begin
        if (sts_i.clr_last) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (in_valid_i) begin
          state_d = StExec;
        end
      end
      StExec: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StClear;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef ASSERT_OFF
  a_issue_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.issue |=> (state_q == StExec))
    else $error("issued item did not move to execute");

  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> !(out_valid_q && out_stall_i))
    else $error("commit over a held result");

  a_valid_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_o.commit))
    else $error("output valid rose without a commit");

  a_clear_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.clr_step |-> !(cmd_o.issue || cmd_o.commit))
    else $error("item activity during clearing pass");
`endif

endmodule

### rtl/core/bit_aligned_field_store.sv
// Bit-aligned field store: get/set of MSB-first bit fields of up to FIELD_BITS bits
// in a byte store of STORE_BYTES bytes. Each item first reads the byte window from
// a set of byte banks (the smallest power of two that covers (FIELD_BITS+14)/8
// bytes, 8 at the defaults), then extracts or merges, writes the changed bytes
// back and loads the result register. A finished result waits in the output
// register while the next item is accepted; a full, stalled output register holds
// the following item in its extract/merge step. After reset the store is cleared
// by a pass over ceil(STORE_BYTES/banks)+1 rows, 129 at the defaults, during which
// in_stall_o is high. A field ending past the store end flags range_error, reads 0
// and writes nothing.
module bit_aligned_field_store import bafs_pkg::*; #(
  parameter int unsigned STORE_BYTES = STORE_BYTES_DEF,
  parameter int unsigned FIELD_BITS  = FIELD_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  bafs_cmd_t cmd;
  bafs_sts_t sts;

  bafs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bafs_datapath #(
    .STORE_BYTES (STORE_BYTES),
    .FIELD_BITS  (FIELD_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_item_i  (in_item_i),
    .out_item_o (out_item_o)
  );

endmodule
